// ===== hw/rtl/bae_pkg.sv =====
// Shared types and constants for the binary arithmetic encoder.
// Used by the front, the command queue, the back and the top level.
package bae_pkg;

	// Operation codes carried on the operation input.
	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	// Split weight is a 12-bit fraction.
	localparam int FRAC_BITS = 12;

	// Width of a byte count that can hold one to four bytes.
	localparam int COUNT_W = 3;

	// One queued command: up to four bytes, first byte in the top lane.
	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [31:0]        bytes;
	} bae_entry_t;

endpackage

// ===== hw/rtl/bae_front.sv =====
// Front of the encoder: accepts items, keeps the coding interval and turns
// each item that emits bytes into a queued byte command. Depends on bae_pkg.
module bae_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                operation,
	input  logic [11:0]         probability,
	input  logic                bit_value,
	input  logic                q_full,
	output logic                q_push,
	output bae_pkg::bae_entry_t q_data
);
	import bae_pkg::*;

	logic [31:0] low_q;
	logic [31:0] high_q;
	logic [31:0] span_q;
	logic        busy_q;

	logic        op_s1;
	logic        bit_s1;
	logic [31:0] prod_hi_s1;
	logic [11:0] prod_lo_s1;

	logic        accept;
	logic [11:0] p_eff;
	logic [31:0] prod_hi;
	logic [23:0] prod_lo;
	logic [31:0] mid;
	logic [31:0] lo_n;
	logic [31:0] hi_n;
	logic [31:0] span_n;
	logic        eq3, eq2, eq1, eq0;
	logic [COUNT_W-1:0] n_bytes;
	logic [31:0] low_next;
	logic [31:0] high_next;
	logic [31:0] span_next;

	assign in_stall = busy_q | q_full;
	assign accept   = in_valid & ~in_stall;

	// A zero weight is used as one.
	assign p_eff   = (probability == 12'd0) ? 12'd1 : probability;
	assign prod_hi = {12'd0, span_q[31:FRAC_BITS]} * {20'd0, p_eff};
	assign prod_lo = {12'd0, span_q[FRAC_BITS-1:0]} * {12'd0, p_eff};

	// Arithmetic cycle: midpoint, narrowed interval and the run of shared top bytes.
	assign mid  = low_q + prod_hi_s1 + {20'd0, prod_lo_s1};
	assign lo_n = bit_s1 ? low_q : mid + 32'd1;
	assign hi_n = bit_s1 ? mid : high_q;
	assign span_n = bit_s1 ? (mid - low_q) : (high_q - mid - 32'd1);

	assign eq3 = lo_n[31:24] == hi_n[31:24];
	assign eq2 = lo_n[23:16] == hi_n[23:16];
	assign eq1 = lo_n[15:8]  == hi_n[15:8];
	assign eq0 = lo_n[7:0]   == hi_n[7:0];

	always_comb begin
		if (!eq3)
			n_bytes = COUNT_W'(0);
		else if (!eq2)
			n_bytes = COUNT_W'(1);
		else if (!eq1)
			n_bytes = COUNT_W'(2);
		else if (!eq0)
			n_bytes = COUNT_W'(3);
		else
			n_bytes = COUNT_W'(4);
	end

	// Shifting out n bytes fills high with ones; the span follows the same rule.
	always_comb begin
		case (n_bytes)
			COUNT_W'(0): begin
				low_next  = lo_n;
				high_next = hi_n;
				span_next = span_n;
			end
			COUNT_W'(1): begin
				low_next  = {lo_n[23:0], 8'h00};
				high_next = {hi_n[23:0], 8'hFF};
				span_next = {span_n[23:0], 8'hFF};
			end
			COUNT_W'(2): begin
				low_next  = {lo_n[15:0], 16'h0000};
				high_next = {hi_n[15:0], 16'hFFFF};
				span_next = {span_n[15:0], 16'hFFFF};
			end
			COUNT_W'(3): begin
				low_next  = {lo_n[7:0], 24'h000000};
				high_next = {hi_n[7:0], 24'hFFFFFF};
				span_next = {span_n[7:0], 24'hFFFFFF};
			end
			default: begin
				low_next  = 32'h00000000;
				high_next = 32'hFFFFFFFF;
				span_next = 32'hFFFFFFFF;
			end
		endcase
	end

	always_comb begin
		q_push = 1'b0;
		q_data = '0;
		if (busy_q) begin
			if (op_s1 == OP_FLUSH) begin
				q_push       = 1'b1;
				q_data.count = COUNT_W'(1);
				q_data.bytes = {low_q[31:24], 24'd0};
			end else begin
				q_push       = n_bytes != COUNT_W'(0);
				q_data.count = n_bytes;
				q_data.bytes = hi_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			low_q  <= 32'h00000000;
			high_q <= 32'hFFFFFFFF;
			span_q <= 32'hFFFFFFFF;
		end else begin
			if (accept)
				busy_q <= 1'b1;
			else if (busy_q)
				busy_q <= 1'b0;
			if (busy_q && op_s1 == OP_ENCODE) begin
				low_q  <= low_next;
				high_q <= high_next;
				span_q <= span_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1      <= operation;
			bit_s1     <= bit_value;
			prod_hi_s1 <= prod_hi;
			prod_lo_s1 <= prod_lo[23:12];
		end
	end

	// The cached span always matches the interval bounds.
	a_span_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		span_q == high_q - low_q)
		else $error("span register out of step with bounds");

	// Nothing is accepted while the arithmetic cycle is in progress.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !accept)
		else $error("item accepted during arithmetic cycle");

endmodule

// ===== hw/rtl/bae_queue.sv =====
// Short command queue between the encoder front and the byte emitter.
// Depends on bae_pkg for the entry type.
module bae_queue #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  bae_pkg::bae_entry_t push_data,
	input  logic                pop,
	output bae_pkg::bae_entry_t head,
	output logic                not_empty,
	output logic                full
);
	import bae_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	bae_entry_t      entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head      = entries_q[rd_ptr_q];
	assign not_empty = count_q != CW'(0);
	assign full      = count_q == CW'(DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_ptr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("command queue underflow");

endmodule

// ===== hw/rtl/bae_back.sv =====
// Back of the encoder: walks queued commands and emits one byte per item,
// marking the final byte of each command. Depends on bae_pkg.
module bae_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  bae_pkg::bae_entry_t q_head,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                last
);
	import bae_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;

	logic       load;
	logic       is_last;
	logic [7:0] sel_byte;

	assign load    = q_valid & (~valid_q | ~out_stall);
	assign is_last = {1'b0, idx_q} == (q_head.count - COUNT_W'(1));
	assign q_pop   = load & is_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = q_head.bytes[31:24];
			2'd1:    sel_byte = q_head.bytes[23:16];
			2'd2:    sel_byte = q_head.bytes[15:8];
			default: sel_byte = q_head.bytes[7:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= is_last;
		end
	end

	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign last      = last_q;

endmodule

// ===== hw/rtl/binary_arithmetic_encoder_unit.sv =====
// Top level of the carry-less 32-bit binary arithmetic encoder.
// Instantiates bae_front, bae_queue and bae_back; depends on bae_pkg.
//
// The encoder keeps a 32-bit code interval and narrows it once per encode
// item, using the item's 12-bit probability (zero counts as one) to place
// the split point; a one bit keeps the lower part, a zero bit the upper.
// Every leading byte that the two bounds then share is emitted, up to four
// per item, and the last byte coming from an item is marked with last.
// A flush item emits the top byte of the low bound, marked last, and does
// not change the interval. The front works on one item at a time: it
// registers the two partial products of span and probability, then in
// its arithmetic cycle adds them to the low bound, narrows the interval
// and writes a byte command into a short queue. The back drains that
// queue at one output byte per cycle unless stalled, so an item that
// emits several bytes keeps the output busy while the front goes on with
// later items; the input stalls only while the front is busy or the
// queue is full. An encode item that emits no byte produces no output
// item at all. After reset the interval is the full 32-bit range.
module binary_arithmetic_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [11:0] probability,
	input  logic        bit_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);
	import bae_pkg::*;

	// Front to queue.
	logic       q_push;
	bae_entry_t q_push_data;
	logic       q_full;

	// Queue to back.
	bae_entry_t q_head;
	logic       q_not_empty;
	logic       q_pop;

	bae_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.probability (probability),
		.bit_value   (bit_value),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	// Holds byte commands while the output side is stalled.
	bae_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.not_empty (q_not_empty),
		.full      (q_full)
	);

	bae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
